>>> hdl/oat_pkg.sv
// package for the ordered array table engine
// holds operation and status codes, the control fsm states and the cell control struct
`default_nettype none

package oat_pkg;

    localparam int DEF_CAPACITY = 128;
    localparam int DATA_W       = 32;
    localparam int OP_W         = 3;
    localparam int POS_W        = 7;
    localparam int STATUS_W     = 2;
    localparam int MATCH_W      = 7;
    localparam int COUNT_W      = 8;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND     = 3'd0,
        OP_DEL_FIRST  = 3'd1,
        OP_DEL_LAST   = 3'd2,
        OP_DEL_AT     = 3'd3,
        OP_SEARCH     = 3'd4,
        OP_REPLACE    = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_BAD       = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_HIT  = 2'd1,
        S_GRP  = 2'd2,
        S_RES  = 2'd3
    } t_state;

    // broadcast to every cell
    typedef struct packed {
        logic              cmp;
        logic [DATA_W-1:0] key;
    } t_cell_ctl;

endpackage

`default_nettype wire

>>> hdl/oat_cell.sv
// one storage cell of the table: an entry register and its match flag
// depends on oat_pkg
`default_nettype none

module oat_cell
    import oat_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_cell_ctl         i_ctl,
    input  wire logic              i_wr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    input  wire logic              i_shift,
    input  wire logic [DATA_W-1:0] i_nbr,
    output logic      [DATA_W-1:0] o_entry,
    output logic                   o_hit
);

    logic [DATA_W-1:0] r_entry;
    logic              r_hit;

    // write and shift never come together
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_entry <= i_wr_data;
        end else if (i_shift) begin
            r_entry <= i_nbr;
        end
        if (i_ctl.cmp) begin
            r_hit <= (r_entry == i_ctl.key);
        end
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;

endmodule

`default_nettype wire

>>> hdl/oat_ffs.sv
// first-match finder: two registered radix-8 levels and a final pick
// depends on oat_pkg
`default_nettype none

module oat_ffs
    import oat_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic                          i_clk,
    input  wire logic [CAPACITY-1:0]           i_hit,
    output logic                               o_found,
    output logic [$clog2(CAPACITY)-1:0]        o_index
);

    localparam int IW  = $clog2(CAPACITY);
    localparam int NG1 = (CAPACITY + 7) / 8;
    localparam int NG2 = (NG1 + 7) / 8;
    localparam int PW  = NG1 * 8;

    logic [PW-1:0] w_hitp;
    logic          n_f1 [NG1];
    logic [IW-1:0] n_i1 [NG1];
    logic          r_f1 [NG1];
    logic [IW-1:0] r_i1 [NG1];
    logic          n_f2 [NG2];
    logic [IW-1:0] n_i2 [NG2];
    logic          r_f2 [NG2];
    logic [IW-1:0] r_i2 [NG2];

    assign w_hitp = PW'(i_hit);

    // level one: lowest hit in each group of eight cells
    always_comb begin
        for (int g = 0; g < NG1; g++) begin
            n_f1[g] = 1'b0;
            n_i1[g] = '0;
            for (int k = 7; k >= 0; k--) begin
                if (w_hitp[g*8+k]) begin
                    n_f1[g] = 1'b1;
                    n_i1[g] = IW'(g*8+k);
                end
            end
        end
    end

    // level two: lowest found group among eight groups
    always_comb begin
        for (int h = 0; h < NG2; h++) begin
            n_f2[h] = 1'b0;
            n_i2[h] = '0;
            for (int k = 7; k >= 0; k--) begin
                if ((h*8+k) < NG1) begin
                    if (r_f1[h*8+k]) begin
                        n_f2[h] = 1'b1;
                        n_i2[h] = r_i1[h*8+k];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1 <= n_f1;
        r_i1 <= n_i1;
        r_f2 <= n_f2;
        r_i2 <= n_i2;
    end

    // final pick over the few second-level groups
    always_comb begin
        o_found = 1'b0;
        o_index = '0;
        for (int h = NG2 - 1; h >= 0; h--) begin
            if (r_f2[h]) begin
                o_found = 1'b1;
                o_index = r_i2[h];
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/ordered_array_table_engine_top.sv
// top level of the ordered array table engine
// depends on oat_pkg, oat_cell and oat_ffs
`default_nettype none

// Ordered table of signed 32-bit entries held in a row of CAPACITY cells, plus
// an entry count. Commands: append, delete first, delete last, delete at a
// position (later entries move down one cell), search for the first match and
// replace the first match. Each command transfer gives exactly one result
// transfer with status, match index and the count after the command.
// Timing: every command but search and replace loads the result register at
// the edge of its transfer; delete first and delete at shift each cell from the
// position upward from its upper neighbor in that edge. For search and replace
// all cells compare in parallel, then two registered radix-8 levels of the
// first-match finder, then the final pick, which also writes the replacement
// into its cell. One command is in flight at a time; a new command is taken in
// the same cycle as the previous result leaves, so the result register never
// stalls the row for more than that. Entries hold no reset value: only cells
// below the count are ever read, so no clearing pass is needed after reset.
module ordered_array_table_engine_top
    import oat_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // command channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [OP_W-1:0]       i_operation,
    input  wire logic signed [DATA_W-1:0] i_value,
    input  wire logic signed [DATA_W-1:0] i_new_value,
    input  wire logic [POS_W-1:0]      i_position,
    // result channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [STATUS_W-1:0]        o_status,
    output logic [MATCH_W-1:0]         o_match_index,
    output logic [COUNT_W-1:0]         o_count_after
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    // control state
    t_state            r_state;
    t_state            n_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_out_valid;

    // held command fields for search and replace
    logic              r_is_repl;
    logic [DATA_W-1:0] r_new_value;

    // result register
    logic [STATUS_W-1:0] r_status;
    logic [MATCH_W-1:0]  r_match;
    logic [COUNT_W-1:0]  r_cnt_out;

    // combinational decode
    logic              w_in_xfer;
    logic              w_out_free;
    logic              w_load;
    t_status           w_status;
    logic [IW-1:0]     w_match_idx;
    t_cell_ctl         w_ctl;
    logic              w_wr_en;
    logic [IW-1:0]     w_wr_idx;
    logic [DATA_W-1:0] w_wr_data;
    logic              w_shift_en;
    logic [XW-1:0]     w_shift_from;
    logic              w_wr     [CAPACITY];
    logic              w_shift  [CAPACITY];
    logic [DATA_W-1:0] w_entry  [CAPACITY];
    logic [CAPACITY-1:0] w_hit_raw;
    logic [CAPACITY-1:0] w_hit;
    logic              w_found;
    logic [IW-1:0]     w_found_idx;
    logic [31:0]       w_cnt_wide;
    logic [31:0]       w_idx_wide;

    // a result can go out when the register is empty or draining this cycle
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_in_xfer  = i_in_valid && o_in_ready;

    // row of cells
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        // the top cell shifts in nothing meaningful: the count drops past it
        localparam int NB = (i + 1 < CAPACITY) ? i + 1 : i;
        oat_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_wr      (w_wr[i]),
            .i_wr_data (w_wr_data),
            .i_shift   (w_shift[i]),
            .i_nbr     (w_entry[NB]),
            .o_entry   (w_entry[i]),
            .o_hit     (w_hit_raw[i])
        );
        // only cells below the count take part in a search
        assign w_hit[i] = w_hit_raw[i] && (CW'(i) < r_count);
    end

    oat_ffs #(
        .CAPACITY (CAPACITY)
    ) u_ffs (
        .i_clk   (i_clk),
        .i_hit   (w_hit),
        .o_found (w_found),
        .o_index (w_found_idx)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer && ((i_operation == OP_SEARCH) ||
                                  (i_operation == OP_REPLACE))) begin
                    n_state = S_HIT;
                end
            end
            S_HIT: begin
                n_state = S_GRP;
            end
            S_GRP: begin
                n_state = S_RES;
            end
            S_RES: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs: cell controls, count update and result
    always_comb begin
        w_ctl.cmp    = 1'b0;
        w_ctl.key    = i_value;
        w_wr_en      = 1'b0;
        w_wr_idx     = r_count[IW-1:0];
        w_wr_data    = i_value;
        w_shift_en   = 1'b0;
        w_shift_from = '0;
        n_count      = r_count;
        w_load       = 1'b0;
        w_status     = ST_OK;
        w_match_idx  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    w_load = 1'b1;
                    unique case (t_op'(i_operation))
                        OP_APPEND: begin
                            if (r_count >= CAP_CNT) begin
                                w_status = ST_FULL;
                            end else begin
                                w_wr_en = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        OP_DEL_FIRST: begin
                            if (r_count == '0) begin
                                w_status = ST_BAD;
                            end else begin
                                w_shift_en = 1'b1;
                                n_count    = r_count - CW'(1);
                            end
                        end
                        OP_DEL_LAST: begin
                            if (r_count == '0) begin
                                w_status = ST_BAD;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        OP_DEL_AT: begin
                            if (XW'(i_position) >= XW'(r_count)) begin
                                w_status = ST_BAD;
                            end else begin
                                w_shift_en   = 1'b1;
                                w_shift_from = XW'(i_position);
                                n_count      = r_count - CW'(1);
                            end
                        end
                        OP_SEARCH, OP_REPLACE: begin
                            // result comes later from the finder
                            w_load    = 1'b0;
                            w_ctl.cmp = 1'b1;
                        end
                        default: begin
                            w_status = ST_BAD;
                        end
                    endcase
                end
            end
            S_HIT, S_GRP: begin
            end
            S_RES: begin
                w_wr_idx  = w_found_idx;
                w_wr_data = r_new_value;
                if (w_out_free) begin
                    w_load = 1'b1;
                    if (w_found) begin
                        w_match_idx = w_found_idx;
                        w_wr_en     = r_is_repl;
                    end else begin
                        w_status = ST_NOT_FOUND;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // per-cell enables
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_wr[i]    = w_wr_en && (w_wr_idx == IW'(i));
            w_shift[i] = w_shift_en && (XW'(i) >= w_shift_from);
        end
    end

    // index and count masked to their field widths
    assign w_cnt_wide = 32'(n_count);
    assign w_idx_wide = 32'(w_match_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_is_repl   <= (i_operation == OP_REPLACE);
            r_new_value <= i_new_value;
        end
        if (w_load) begin
            r_status  <= w_status;
            r_match   <= w_idx_wide[MATCH_W-1:0];
            r_cnt_out <= w_cnt_wide[COUNT_W-1:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_match_index = r_match;
    assign o_count_after = r_cnt_out;

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// self-checking testbench for ordered_array_table_engine_top
// depends on oat_pkg and the engine rtl; predicts every result with its own table copy
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import oat_pkg::*;

    localparam int CAP          = DEF_CAPACITY;
    localparam int N_ITEMS      = 1100;
    localparam int IDLE_LIMIT   = 2000;   // cycles with no transfer before giving up
    localparam int TAIL_CYCLES  = 20;     // plenty of margin after the queues drain
    localparam int HOLDOFF_AT   = 400;    // commands taken before the long receiver stall
    localparam int HOLDOFF_LEN  = 300;
    localparam int MAX_REPORTS  = 10;

    // codes outside the operation enum, the block must reject them
    localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] val;
        logic signed [DATA_W-1:0] nval;
        logic [POS_W-1:0]         pos;
        logic [7:0]               gap;    // idle cycles offered before this command
        logic                     drain;  // hold this command until all results are back
    } t_table_cmd;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        t_status            status;
        logic [MATCH_W-1:0] match;
        logic [COUNT_W-1:0] count;
    } t_table_res;

    // dut signals; the inputs are known from time zero
    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_in_valid    = 1'b0;
    logic                     o_in_ready;
    logic [OP_W-1:0]          i_operation   = '0;
    logic signed [DATA_W-1:0] i_value       = '0;
    logic signed [DATA_W-1:0] i_new_value   = '0;
    logic [POS_W-1:0]         i_position    = '0;
    logic                     o_out_valid;
    logic                     i_out_ready   = 1'b0;
    logic [STATUS_W-1:0]      o_status;
    logic [MATCH_W-1:0]       o_match_index;
    logic [COUNT_W-1:0]       o_count_after;

    ordered_array_table_engine_top #(
        .CAPACITY(CAP)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_operation   (i_operation),
        .i_value       (i_value),
        .i_new_value   (i_new_value),
        .i_position    (i_position),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_match_index (o_match_index),
        .o_count_after (o_count_after)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // command stream and predicted results
    t_table_cmd cmd_queue[$];
    t_table_res predicted_results[$];

    // shadow of the engine state used by the predictor
    logic signed [DATA_W-1:0] tbl_entries [CAP];
    int                       tbl_count = 0;

    // stimulus generation bookkeeping
    int                       gen_count = 0;   // count as it will be after queued commands
    logic signed [DATA_W-1:0] value_pool [16];

    int  err_count     = 0;
    int  cmds_accepted = 0;
    bit  cmd_taken     = 1'b0;   // command transfer at the last rising edge
    int  idle_cycles   = 0;

    // ------------------------------------------------------------------
    // predictor: applies one command to the shadow table
    // ------------------------------------------------------------------
    function automatic t_table_res apply_table_cmd(t_table_cmd c);
        t_table_res r;
        int         i;
        int         idx;
        bit         hit;
        r.op     = c.op;
        r.status = ST_OK;
        r.match  = '0;
        hit      = 1'b0;
        idx      = 0;
        case (c.op)
            OP_APPEND: begin
                if (tbl_count >= CAP) begin
                    r.status = ST_FULL;
                end else begin
                    tbl_entries[tbl_count] = c.val;
                    tbl_count++;
                end
            end
            OP_DEL_FIRST, OP_DEL_AT: begin
                idx = (c.op == OP_DEL_FIRST) ? 0 : int'(c.pos);
                if (idx >= tbl_count) begin
                    // also covers the empty table
                    r.status = ST_BAD;
                end else begin
                    for (i = idx; i + 1 < tbl_count; i++)
                        tbl_entries[i] = tbl_entries[i + 1];
                    tbl_count--;
                end
            end
            OP_DEL_LAST: begin
                if (tbl_count == 0) r.status = ST_BAD;
                else tbl_count--;
            end
            OP_SEARCH, OP_REPLACE: begin
                for (i = 0; i < tbl_count; i++) begin
                    if (!hit && tbl_entries[i] == c.val) begin
                        hit = 1'b1;
                        idx = i;
                    end
                end
                if (hit) begin
                    r.match = idx[MATCH_W-1:0];
                    if (c.op == OP_REPLACE) tbl_entries[idx] = c.nval;
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            default: begin
                r.status = ST_BAD;
            end
        endcase
        r.count = tbl_count[COUNT_W-1:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // pool values make searches and replaces hit often
    function automatic logic signed [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 9) < 7) return value_pool[$urandom_range(0, 15)];
        return $urandom;
    endfunction

    // queue one command and track the count it will leave behind
    task automatic push_cmd(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] val,
                            input logic signed [DATA_W-1:0] nval, input int pos,
                            input int unsigned gap, input bit drain);
        t_table_cmd c;
        c.op    = op;
        c.val   = val;
        c.nval  = nval;
        c.pos   = pos[POS_W-1:0];
        c.gap   = (gap > 255) ? 8'd255 : gap[7:0];
        c.drain = drain;
        case (op)
            OP_APPEND:                if (gen_count < CAP) gen_count++;
            OP_DEL_FIRST, OP_DEL_LAST: if (gen_count > 0) gen_count--;
            OP_DEL_AT:                if (pos < gen_count) gen_count--;
            default: ;
        endcase
        cmd_queue.push_back(c);
    endtask

    // random command from the general mix
    task automatic push_mixed(input bit eager, input bit drain);
        int unsigned r;
        int unsigned gap;
        int          pos;
        r   = $urandom_range(0, 99);
        gap = eager ? 0 : pick_gap();
        pos = $urandom_range(0, 127);
        if (r < 28) begin
            push_cmd(OP_APPEND, pick_value(), $urandom, pos, gap, drain);
        end else if (r < 36) begin
            push_cmd(OP_DEL_FIRST, $urandom, $urandom, pos, gap, drain);
        end else if (r < 44) begin
            push_cmd(OP_DEL_LAST, $urandom, $urandom, pos, gap, drain);
        end else if (r < 58) begin
            // mostly a valid position, sometimes anywhere in the field
            if (gen_count > 0 && $urandom_range(0, 4) != 0)
                pos = $urandom_range(0, gen_count - 1);
            push_cmd(OP_DEL_AT, $urandom, $urandom, pos, gap, drain);
        end else if (r < 78) begin
            push_cmd(OP_SEARCH, pick_value(), $urandom, pos, gap, drain);
        end else if (r < 96) begin
            push_cmd(OP_REPLACE, pick_value(),
                     ($urandom_range(0, 1) != 0) ? pick_value() : $urandom, pos, gap, drain);
        end else begin
            push_cmd(($urandom_range(0, 1) != 0) ? OP_RSVD6 : OP_RSVD7,
                     $urandom, $urandom, pos, gap, drain);
        end
    endtask

    task automatic build_stimulus();
        int  i;
        int  n;
        int  phase_no;
        int  pos;
        bit  eager;
        logic [OP_W-1:0] op;

        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7fff_ffff;
        value_pool[2] = 32'sh0000_0000;
        value_pool[3] = -32'sd1;
        for (i = 4; i < 16; i++) value_pool[i] = $urandom;

        // directed: empty-table deletes and lookups, rejected opcodes
        push_cmd(OP_DEL_FIRST, 0, 0, 0, pick_gap(), 1'b0);
        push_cmd(OP_DEL_LAST, 0, 0, 0, pick_gap(), 1'b0);
        push_cmd(OP_DEL_AT, 0, 0, 0, pick_gap(), 1'b0);
        push_cmd(OP_SEARCH, 0, 0, 0, pick_gap(), 1'b0);
        push_cmd(OP_REPLACE, 0, 1, 0, pick_gap(), 1'b0);
        push_cmd(OP_RSVD6, -32'sd1, -32'sd1, 127, pick_gap(), 1'b0);
        push_cmd(OP_RSVD7, 32'sh8000_0000, 32'sh7fff_ffff, 0, pick_gap(), 1'b0);
        // directed: extremes and a duplicate so the first match matters
        push_cmd(OP_APPEND, 32'sh8000_0000, 0, 0, 0, 1'b0);
        push_cmd(OP_APPEND, 32'sh7fff_ffff, 0, 0, 0, 1'b0);
        push_cmd(OP_APPEND, 0, 0, 0, 0, 1'b0);
        push_cmd(OP_APPEND, -32'sd1, 0, 0, 0, 1'b0);
        push_cmd(OP_APPEND, 0, 0, 0, 0, 1'b0);
        push_cmd(OP_SEARCH, 0, 0, 0, pick_gap(), 1'b0);
        push_cmd(OP_REPLACE, 0, 32'sh8000_0000, 0, pick_gap(), 1'b0);
        push_cmd(OP_SEARCH, 0, 0, 0, pick_gap(), 1'b0);
        push_cmd(OP_SEARCH, 32'sd12345, 0, 0, pick_gap(), 1'b0);
        // directed: position beyond and at the count, then valid ones
        push_cmd(OP_DEL_AT, 0, 0, 127, pick_gap(), 1'b0);
        push_cmd(OP_DEL_AT, 0, 0, 5, pick_gap(), 1'b0);
        push_cmd(OP_DEL_AT, 0, 0, 4, pick_gap(), 1'b0);
        push_cmd(OP_DEL_AT, 0, 0, 0, pick_gap(), 1'b0);
        push_cmd(OP_DEL_FIRST, 0, 0, 0, pick_gap(), 1'b0);
        push_cmd(OP_DEL_LAST, 0, 0, 0, pick_gap(), 1'b0);
        push_cmd(OP_DEL_LAST, 0, 0, 0, pick_gap(), 1'b0);
        push_cmd(OP_DEL_LAST, 0, 0, 0, pick_gap(), 1'b0);

        // random phases: general mix, fill to full, drain to empty
        phase_no = 0;
        while (cmd_queue.size() < N_ITEMS) begin
            eager = ($urandom_range(0, 2) == 0);
            case (phase_no % 6)
                2: begin
                    while (gen_count < CAP)
                        push_cmd(OP_APPEND, pick_value(), $urandom, $urandom_range(0, 127),
                                 eager ? 0 : pick_gap(), 1'b0);
                    // appends on a full table, then lookups and deletes near the top
                    for (i = 0; i < 3; i++)
                        push_cmd(OP_APPEND, $urandom, $urandom, 0, pick_gap(), 1'b0);
                    push_cmd(OP_DEL_AT, 0, 0, 127, pick_gap(), 1'b0);
                    push_cmd(OP_APPEND, 32'sh7fff_ffff, 0, 0, pick_gap(), 1'b0);
                    for (i = 0; i < 6; i++) push_mixed(eager, 1'b0);
                end
                5: begin
                    while (gen_count > 0) begin
                        n = $urandom_range(0, 2);
                        op = (n == 0) ? OP_DEL_FIRST : (n == 1) ? OP_DEL_LAST : OP_DEL_AT;
                        pos = $urandom_range(0, gen_count - 1);
                        push_cmd(op, $urandom, $urandom, pos, eager ? 0 : pick_gap(), 1'b0);
                    end
                    push_cmd(OP_DEL_AT, 0, 0, $urandom_range(0, 127), pick_gap(), 1'b0);
                    push_cmd(OP_DEL_FIRST, 0, 0, 0, pick_gap(), 1'b0);
                    push_cmd(OP_SEARCH, pick_value(), 0, 0, pick_gap(), 1'b0);
                end
                default: begin
                    // the first command of every sixth phase waits for a quiet engine
                    for (i = 0; i < 40; i++)
                        push_mixed(eager, (i == 0) && (phase_no % 6 == 0));
                end
            endcase
            phase_no++;
        end
    endtask

    // ------------------------------------------------------------------
    // driver: command channel, changes on the falling edge
    // ------------------------------------------------------------------
    int unsigned tx_wait = 0;

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            // a command still waiting for its transfer is held as is
            if (!i_in_valid || cmd_taken) begin
                if (cmd_queue.size() == 0 ||
                    (cmd_queue[0].drain && predicted_results.size() > 0)) begin
                    i_in_valid <= 1'b0;
                end else if (tx_wait < cmd_queue[0].gap) begin
                    tx_wait++;
                    i_in_valid <= 1'b0;
                end else begin
                    tx_wait = 0;
                    i_operation <= cmd_queue[0].op;
                    i_value     <= cmd_queue[0].val;
                    i_new_value <= cmd_queue[0].nval;
                    i_position  <= cmd_queue[0].pos;
                    i_in_valid  <= 1'b1;
                    void'(cmd_queue.pop_front());
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: result channel ready, random stalls plus one long hold-off
    // ------------------------------------------------------------------
    int unsigned rx_stall      = 0;
    int unsigned rx_phase_left = 0;
    int unsigned holdoff_left  = 0;
    bit          rx_eager      = 1'b0;
    bit          holdoff_done  = 1'b0;

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            // stall the result side long enough that the engine backs up into its input
            if (!holdoff_done && cmds_accepted >= HOLDOFF_AT) begin
                holdoff_left = HOLDOFF_LEN;
                holdoff_done = 1'b1;
            end
            // stretches that are either always-ready or random stalls, picked at random
            if (rx_phase_left == 0) begin
                rx_eager      = ($urandom_range(0, 2) == 0);
                rx_phase_left = $urandom_range(50, 300);
            end else begin
                rx_phase_left--;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                i_out_ready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (!rx_eager) rx_stall = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: sample both channels on the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_table_cmd c;
        t_table_res r;
        cmd_taken = 1'b0;
        if (i_rst_n) begin
            // result transfer checked against the oldest prediction
            if (o_out_valid && i_out_ready) begin
                if (predicted_results.size() == 0) begin
                    if (err_count < MAX_REPORTS)
                        $display("unexpected result transfer: status %0d match %0d count %0d",
                                 o_status, o_match_index, o_count_after);
                    err_count++;
                end else begin
                    r = predicted_results.pop_front();
                    if (o_status !== r.status || o_match_index !== r.match ||
                        o_count_after !== r.count) begin
                        if (err_count < MAX_REPORTS) begin
                            $display("result mismatch op %0d: expected status %0d match %0d count %0d",
                                     r.op, r.status, r.match, r.count);
                            $display("  got status %0d match %0d count %0d",
                                     o_status, o_match_index, o_count_after);
                        end
                        err_count++;
                    end
                end
            end
            // command transfer: predict its result now, in acceptance order
            if (i_in_valid && o_in_ready) begin
                c.op    = i_operation;
                c.val   = i_value;
                c.nval  = i_new_value;
                c.pos   = i_position;
                c.gap   = '0;
                c.drain = 1'b0;
                predicted_results.push_back(apply_table_cmd(c));
                cmds_accepted++;
                cmd_taken = 1'b1;
            end
        end
    end

    // watchdog: too long without any transfer on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence: build stimulus, reset, wait for everything to drain
    // ------------------------------------------------------------------
    initial begin
        build_stimulus();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || i_in_valid || predicted_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (predicted_results.size() != 0) err_count++;
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> ordered_array_table_engine_top.f
hdl/oat_pkg.sv
hdl/oat_cell.sv
hdl/oat_ffs.sv
hdl/ordered_array_table_engine_top.sv
tb/sv/tb_top.sv
